FILE: rtl/core/hsvg_pkg.sv
// Shared widths and helpers for the hypercube simplex vertex generator.
package hsvg_pkg;

    localparam int DIM_MAX = 8;
    localparam int DIM_W   = 4;
    localparam int VERT_W  = 8;
    localparam int PERM_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

    typedef logic [PERM_W-1:0] t_perm;
    typedef logic [DIM_W-1:0]  t_pos;

    // Clamp the programmed dimension into 1..DIM_MAX.
    function automatic t_pos active_dim(input t_pos dim);
        t_pos res;
        if (dim == '0) begin
            res = t_pos'(1);
        end else if (dim > t_pos'(DIM_MAX)) begin
            res = t_pos'(DIM_MAX);
        end else begin
            res = dim;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/hypercube_simplex_vertex_generator_unit.sv
// Kuhn triangulation vertex generator: sequencer, permutation memory and output register.
//
// Walks the n! simplices of the Kuhn triangulation of the unit n-cube in lexicographic
// permutation order, n being the dimension register (0 reads as 1, values above DIM_MAX
// read as DIM_MAX). Each accepted request word yields n+1 vertex words: vertex 0 is the
// origin and vertex v+1 sets coordinate perm[v] of vertex v. final_simplex is high on every
// vertex of a simplex built from the last permutation, after which the order wraps to the
// identity. restart, and any write of the dimension register, puts the permutation back to
// the identity; the fill runs at the start of the next request. A vertex word held off by
// the vertex channel stalls the walk. One comparator is shared by the scan for the pivot
// and the search for the swap partner, and one memory write port by the identity fill,
// the swap and the tail reversal. The block takes no request until the permutation has
// been advanced; the last vertex word may still be waiting in the output register when
// the next request is taken.
module hypercube_simplex_vertex_generator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: dimension register
    input  logic                       i_cfg_wr_en,
    input  logic [hsvg_pkg::DIM_W-1:0] i_cfg_wr_data,
    // request channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_restart,
    // vertex channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hsvg_pkg::VERT_W-1:0] o_vertex_bits,
    output logic [hsvg_pkg::DIM_W-1:0]  o_vertex_number,
    output logic                        o_last_vertex,
    output logic                        o_final_simplex
);
    import hsvg_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_EMIT_RD  = 4'd4;
    localparam logic [3:0] S_EMIT_WR  = 4'd5;
    localparam logic [3:0] S_J_RD     = 4'd6;
    localparam logic [3:0] S_J_CMP    = 4'd7;
    localparam logic [3:0] S_SWAP     = 4'd8;
    localparam logic [3:0] S_REV_RD   = 4'd9;
    localparam logic [3:0] S_REV_W1   = 4'd10;
    localparam logic [3:0] S_REV_W2   = 4'd11;

    // Permutation memory: one write port, two registered read ports.
    t_perm r_perm_mem [DIM_MAX];
    t_perm r_rd_a, r_rd_b;
    t_perm mem_addr_a, mem_addr_b, mem_waddr, mem_wdata;
    logic  mem_we;

    logic [3:0]        r_state, n_state;
    t_pos              r_dimension;
    logic              r_ident_pend, n_ident_pend;
    t_pos              r_cnt, n_cnt;       // fill index, then vertex number
    t_pos              r_pos_lo, n_pos_lo; // pivot i, then lower reversal end
    t_pos              r_pos_hi, n_pos_hi; // scan k, partner j, upper reversal end
    logic              r_found, n_found;   // pivot found: not the last permutation
    t_perm             r_hold, n_hold;
    logic [VERT_W-1:0] r_acc, n_acc;

    logic              r_out_valid, n_out_valid;
    logic [VERT_W-1:0] r_out_bits, n_out_bits;
    t_pos              r_out_num, n_out_num;
    logic              r_out_last, n_out_last;
    logic              r_out_final, n_out_final;

    t_pos              dim_n, dim_top, cnt_m1, hi_m1;
    logic              cmp_lt, slot_free, accept;
    logic [VERT_W-1:0] vert_next;

    assign dim_n   = active_dim(r_dimension);
    assign dim_top = dim_n - t_pos'(1);
    assign cnt_m1  = r_cnt - t_pos'(1);
    assign hi_m1   = r_pos_hi - t_pos'(1);

    // the shared comparator: port A entry below port B entry
    assign cmp_lt = (r_rd_a < r_rd_b);

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;

    // next vertex: origin first, then set the coordinate just read
    assign vert_next = (r_cnt == '0) ? '0 : (r_acc | (VERT_W'(1) << r_rd_a));

    always_comb begin
        n_state      = r_state;
        n_ident_pend = r_ident_pend;
        n_cnt        = r_cnt;
        n_pos_lo     = r_pos_lo;
        n_pos_hi     = r_pos_hi;
        n_found      = r_found;
        n_hold       = r_hold;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_bits   = r_out_bits;
        n_out_num    = r_out_num;
        n_out_last   = r_out_last;
        n_out_final  = r_out_final;
        mem_addr_a   = r_pos_lo[PERM_W-1:0];
        mem_addr_b   = r_pos_hi[PERM_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = r_pos_lo[PERM_W-1:0];
        mem_wdata    = r_rd_b;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos_hi = dim_top;
                    n_found  = 1'b0;
                    if (i_restart || r_ident_pend) begin
                        n_cnt        = '0;
                        n_ident_pend = 1'b0;
                        n_state      = S_INIT;
                    end else if (dim_top == '0) begin
                        n_cnt   = '0;
                        n_state = S_EMIT_WR;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_INIT: begin
                // fill the first n entries with the identity
                mem_we    = 1'b1;
                mem_waddr = r_cnt[PERM_W-1:0];
                mem_wdata = r_cnt[PERM_W-1:0];
                if (r_cnt == dim_top) begin
                    n_cnt = '0;
                    if (dim_top == '0) begin
                        n_state = S_EMIT_WR;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_cnt = r_cnt + t_pos'(1);
                end
            end
            S_SCAN_RD: begin
                mem_addr_a = hi_m1[PERM_W-1:0];
                n_state    = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                // look for the rightmost ascent perm[k-1] < perm[k]
                mem_addr_a = hi_m1[PERM_W-1:0];
                if (cmp_lt) begin
                    n_pos_lo = hi_m1;
                    n_found  = 1'b1;
                    n_cnt    = '0;
                    n_state  = S_EMIT_WR;
                end else if (r_pos_hi == t_pos'(1)) begin
                    n_cnt   = '0;
                    n_state = S_EMIT_WR;
                end else begin
                    n_pos_hi = hi_m1;
                    n_state  = S_SCAN_RD;
                end
            end
            S_EMIT_RD: begin
                mem_addr_a = cnt_m1[PERM_W-1:0];
                n_state    = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                mem_addr_a = cnt_m1[PERM_W-1:0];
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_bits  = vert_next;
                    n_out_num   = r_cnt;
                    n_out_last  = (r_cnt == dim_n);
                    n_out_final = !r_found;
                    n_acc       = vert_next;
                    if (r_cnt == dim_n) begin
                        n_pos_hi = dim_top;
                        if (r_found) begin
                            n_state = S_J_RD;
                        end else begin
                            // last permutation: reverse the whole prefix
                            n_pos_lo = '0;
                            n_state  = S_REV_RD;
                        end
                    end else begin
                        n_cnt   = r_cnt + t_pos'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_J_RD: begin
                n_state = S_J_CMP;
            end
            S_J_CMP: begin
                // rightmost j with perm[i] < perm[j]; write perm[j] into slot i
                if (cmp_lt) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos_lo[PERM_W-1:0];
                    mem_wdata = r_rd_b;
                    n_hold    = r_rd_a;
                    n_state   = S_SWAP;
                end else begin
                    n_pos_hi = hi_m1;
                    n_state  = S_J_RD;
                end
            end
            S_SWAP: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos_hi[PERM_W-1:0];
                mem_wdata = r_hold;
                n_pos_lo  = r_pos_lo + t_pos'(1);
                n_pos_hi  = dim_top;
                n_state   = S_REV_RD;
            end
            S_REV_RD: begin
                if (r_pos_lo < r_pos_hi) begin
                    n_state = S_REV_W1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REV_W1: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos_lo[PERM_W-1:0];
                mem_wdata = r_rd_b;
                n_hold    = r_rd_a;
                n_state   = S_REV_W2;
            end
            S_REV_W2: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos_hi[PERM_W-1:0];
                mem_wdata = r_hold;
                n_pos_lo  = r_pos_lo + t_pos'(1);
                n_pos_hi  = hi_m1;
                n_state   = S_REV_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a dimension write always calls for a fresh identity
        if (i_cfg_wr_en) begin
            n_ident_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_perm_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_perm_mem[mem_addr_a];
        r_rd_b <= r_perm_mem[mem_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dimension  <= t_pos'(2);
            r_ident_pend <= 1'b1;
            r_out_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_acc        <= '0;
        end else begin
            r_state      <= n_state;
            r_ident_pend <= n_ident_pend;
            r_out_valid  <= n_out_valid;
            r_found      <= n_found;
            r_acc        <= n_acc;
            if (i_cfg_wr_en) begin
                r_dimension <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_pos_lo    <= n_pos_lo;
        r_pos_hi    <= n_pos_hi;
        r_hold      <= n_hold;
        r_out_bits  <= n_out_bits;
        r_out_num   <= n_out_num;
        r_out_last  <= n_out_last;
        r_out_final <= n_out_final;
    end

    assign o_valid         = r_out_valid;
    assign o_vertex_bits   = r_out_bits;
    assign o_vertex_number = r_out_num;
    assign o_last_vertex   = r_out_last;
    assign o_final_simplex = r_out_final;

endmodule

FILE: sim/hsvg_checker.sv
`timescale 1ns / 100ps
// Checker for the vertex generator: predicts vertex words from requests and compares them.
module hsvg_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [hsvg_pkg::DIM_W-1:0]  i_cfg_wr_data,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic                        i_req_restart,
    input  logic                        i_vtx_valid,
    input  logic                        i_vtx_ready,
    input  logic [hsvg_pkg::VERT_W-1:0] i_vertex_bits,
    input  logic [hsvg_pkg::DIM_W-1:0]  i_vertex_number,
    input  logic                        i_last_vertex,
    input  logic                        i_final_simplex,
    output int                          o_fail_count,
    output int                          o_pending
);

    import hsvg_pkg::*;

    typedef struct packed {
        logic [VERT_W-1:0] bits;
        logic [DIM_W-1:0]  number;
        logic              last;
        logic              wrap;
    } t_vertex_word;

    t_perm        order_q [DIM_MAX];
    t_pos         dim_q;
    t_vertex_word vertex_words_q [$];
    int           fails = 0;

    function automatic int clamped_dim(input t_pos d);
        int n;
        n = int'(d);
        if (n < 1) n = 1;
        if (n > DIM_MAX) n = DIM_MAX;
        return n;
    endfunction

    task automatic load_identity();
        int k;
        for (k = 0; k < DIM_MAX; k++) order_q[k] = t_perm'(k);
    endtask

    function automatic void flip_range(input int lo, input int hi);
        t_perm t;
        while (lo < hi) begin
            t           = order_q[lo];
            order_q[lo] = order_q[hi];
            order_q[hi] = t;
            lo++;
            hi--;
        end
    endfunction

    // Step the order to its lexicographic successor; 1 when it wraps round.
    function automatic bit step_order(input int n);
        int    pivot;
        int    k;
        int    j;
        t_perm t;
        pivot = -1;
        for (k = n - 1; k > 0; k--) begin
            if (pivot < 0 && order_q[k-1] < order_q[k]) pivot = k - 1;
        end
        if (pivot < 0) begin
            flip_range(0, n - 1);
            return 1'b1;
        end
        j = n - 1;
        while (order_q[j] <= order_q[pivot]) j--;
        t              = order_q[pivot];
        order_q[pivot] = order_q[j];
        order_q[j]     = t;
        flip_range(pivot + 1, n - 1);
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : model
        t_perm             held [DIM_MAX];
        logic [VERT_W-1:0] acc;
        t_vertex_word      w;
        bit                wrapped;
        int                n;
        int                v;
        if (!i_rst_n) begin
            dim_q = t_pos'(2);
            load_identity();
            vertex_words_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                dim_q = i_cfg_wr_data;
                load_identity();
            end
            if (i_req_valid && i_req_ready) begin
                n = clamped_dim(dim_q);
                if (i_req_restart) load_identity();
                held    = order_q;
                wrapped = step_order(n);
                acc     = '0;
                for (v = 0; v <= n; v++) begin
                    if (v > 0) acc = acc | (VERT_W'(1) << held[v-1]);
                    w.bits   = acc;
                    w.number = t_pos'(v);
                    w.last   = (v == n);
                    w.wrap   = wrapped;
                    vertex_words_q = {vertex_words_q, w};
                end
            end
            if (i_vtx_valid && i_vtx_ready) begin
                if (vertex_words_q.size() == 0) begin
                    $display("%0t: unexpected vertex word, expected none, actual bits %h number %0d",
                             $time, i_vertex_bits, i_vertex_number);
                    fails++;
                end else begin
                    w = vertex_words_q.pop_front();
                    check_field("vertex_bits", w.bits, i_vertex_bits);
                    check_field("vertex_number", w.number, i_vertex_number);
                    check_field("last_vertex", w.last, i_last_vertex);
                    check_field("final_simplex", w.wrap, i_final_simplex);
                end
            end
        end
        o_pending    <= vertex_words_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the vertex generator testbench: clock, reset, request and ready stimulus, verdict.
module tb_top;

    import hsvg_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // Tail after the last word: the permutation may still be swapping or reversing.
    localparam int SETTLE_CYCLES = 9 * DIM_MAX + 30;
    localparam int HOLD_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 500000;

    logic             i_clk;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_wr_en     = 1'b0;
    logic [DIM_W-1:0] i_cfg_wr_data   = '0;
    logic             i_valid         = 1'b0;
    logic             i_restart       = 1'b0;
    logic             i_ready         = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [VERT_W-1:0] o_vertex_bits;
    logic [DIM_W-1:0]  o_vertex_number;
    logic              o_last_vertex;
    logic              o_final_simplex;

    int         fail_count;
    int         pending;
    int         cycles     = 0;
    t_idle_mode idle_mode  = IDLE_NONE;
    int         stall_ask  = 0;
    int         stall_seen = 0;
    int         hold_left  = 0;

    hypercube_simplex_vertex_generator_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_restart       (i_restart),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_vertex_bits   (o_vertex_bits),
        .o_vertex_number (o_vertex_number),
        .o_last_vertex   (o_last_vertex),
        .o_final_simplex (o_final_simplex)
    );

    hsvg_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_restart   (i_restart),
        .i_vtx_valid     (o_valid),
        .i_vtx_ready     (i_ready),
        .i_vertex_bits   (o_vertex_bits),
        .i_vertex_number (o_vertex_number),
        .i_last_vertex   (o_last_vertex),
        .i_final_simplex (o_final_simplex),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the words stop coming.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int send_idle_pct(input t_idle_mode m);
        case (m)
            IDLE_SEND: return 46;
            IDLE_BOTH: return 38;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input t_idle_mode m);
        case (m)
            IDLE_RECV: return 46;
            IDLE_BOTH: return 38;
            default:   return 0;
        endcase
    endfunction

    // Vertex receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (stall_seen != stall_ask) begin
            stall_seen <= stall_ask;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct(idle_mode));
        end
    end

    // Offer one request word and hold it until accepted. Idle first, per cycle, as the
    // current mode says; drop valid only across such a gap so back-to-back words stay high.
    task automatic send_request(input logic restart);
        while ($urandom_range(99) < send_idle_pct(idle_mode)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait until every expected vertex word has come back.
    task automatic wait_for_words();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write the dimension only once the block has gone quiet.
    task automatic write_dim(input logic [DIM_W-1:0] value);
        wait_for_words();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] dim, input t_idle_mode mode,
                             input int count, input int restart_pct, input bit long_hold);
        int i;
        write_dim(dim);
        idle_mode <= mode;
        if (long_hold) stall_ask <= stall_ask + 1;
        for (i = 0; i < count; i++) begin
            // Pause halfway until the block has fully drained.
            if (i == count / 2) wait_for_words();
            send_request($urandom_range(99) < restart_pct);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset dimension two, through the wrap, then a restart.
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        // Dimension one: every simplex is the final one.
        write_dim(DIM_W'(1));
        send_request(1'b0);
        send_request(1'b1);
        // Dimension three: full cycle of six, wrap, then restart.
        write_dim(DIM_W'(3));
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        // Zero reads as one; fifteen saturates to the maximum.
        write_dim(DIM_W'(0));
        send_request(1'b0);
        write_dim(DIM_W'(15));
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // Random phases; the dimension five run is long enough to wrap without restarts.
        run_phase(DIM_W'(3), IDLE_NONE, 30, 8, 1'b1);
        run_phase(DIM_W'(4), IDLE_SEND, 60, 8, 1'b0);
        run_phase(DIM_W'(2), IDLE_RECV, 30, 10, 1'b0);
        run_phase(DIM_W'(5), IDLE_BOTH, 130, 0, 1'b0);
        run_phase(DIM_W'(8), IDLE_SEND, 20, 10, 1'b1);
        run_phase(DIM_W'(1), IDLE_RECV, 15, 20, 1'b0);
        run_phase(DIM_W'(6), IDLE_BOTH, 40, 5, 1'b0);
        run_phase(DIM_W'(9), IDLE_NONE, 20, 10, 1'b0);
        run_phase(DIM_W'(4), IDLE_RECV, 35, 8, 1'b1);

        wait_for_words();
        idle_mode <= IDLE_NONE;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
